[rtl/core/utf8_validating_decoder_unit_defines.svh]
// Assertion macros shared by the UTF-8 validating decoder.
// Included by the top level; needs no other file.
`ifndef UTF8_VALIDATING_DECODER_UNIT_DEFINES_SVH
`define UTF8_VALIDATING_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UTF8VD_ASSERT_IMPLY(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("utf8 decoder: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define UTF8VD_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("utf8 decoder: next-cycle check failed");

`endif

[rtl/core/utf8vd_pkg.sv]
// Types and constants of the UTF-8 validating decoder.
// Used by utf8vd_decode and utf8_validating_decoder_unit; no dependencies.
package utf8vd_pkg;

    localparam int CpWidth = 21;

    // Result status codes.
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_STRAY_CONT  = 3'd1;
    localparam logic [2:0] ST_ILLEGAL     = 3'd2;
    localparam logic [2:0] ST_BAD_CONT    = 3'd3;
    localparam logic [2:0] ST_OVERLONG    = 3'd4;
    localparam logic [2:0] ST_SURROGATE   = 3'd5;
    localparam logic [2:0] ST_TOO_BIG     = 3'd6;

    // Octet class boundaries.
    localparam logic [7:0] ASCII_MAX      = 8'h7F;
    localparam logic [7:0] CONT_MAX       = 8'hBF;
    localparam logic [7:0] ILLEGAL_LO_MAX = 8'hC1;
    localparam logic [7:0] LEAD2_MAX      = 8'hDF;
    localparam logic [7:0] LEAD3_MAX      = 8'hEF;
    localparam logic [7:0] LEAD4_MAX      = 8'hF4;
    localparam logic [7:0] LEAD3_BASE     = 8'hE0;
    localparam logic [7:0] LEAD4_BASE     = 8'hF0;

    // Code point limits.
    localparam logic [CpWidth-1:0] MIN_3BYTE     = 21'h000800;
    localparam logic [CpWidth-1:0] MIN_4BYTE     = 21'h010000;
    localparam logic [CpWidth-1:0] SURROGATE_LO  = 21'h00D800;
    localparam logic [CpWidth-1:0] SURROGATE_HI  = 21'h00DFFF;
    localparam logic [CpWidth-1:0] MAX_SCALAR    = 21'h10FFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       string_end;
    } utf8vd_in_t;

    typedef struct packed {
        logic [CpWidth-1:0] code_point;
        logic [2:0]         status;
        logic [7:0]         bad_octet;
        logic [15:0]        error_position;
        logic               last_result;
    } utf8vd_out_t;

    // Sequence state carried from octet to octet.
    typedef struct packed {
        logic [CpWidth-1:0] partial_value;
        logic [1:0]         bytes_due;
        logic [1:0]         sequence_length;
        logic               error_latched;
    } utf8vd_seq_t;

endpackage

[rtl/core/utf8vd_decode.sv]
// Single-octet decode step: sequence state plus one octet gives the next state
// and at most one result. Depends on utf8vd_pkg.
module utf8vd_decode
    import utf8vd_pkg::*;
#(
    parameter int POSITION_WIDTH = 16
)
(
    input  utf8vd_in_t                item,
    input  utf8vd_seq_t               seq,
    input  logic [POSITION_WIDTH-1:0] byte_index,
    output utf8vd_seq_t               seq_next,
    output logic [POSITION_WIDTH-1:0] byte_index_next,
    output logic                      emit,
    output utf8vd_out_t               result
);

    logic [POSITION_WIDTH-1:0]    pos_plus1;
    logic [POSITION_WIDTH+15:0]   pos_wide;
    logic [POSITION_WIDTH+15:0]   next_wide;
    logic [CpWidth-1:0]           value;
    logic [1:0]                   due_left;
    logic [1:0]                   lead_due;
    logic [CpWidth-1:0]           lead_init;
    logic [2:0]                   status;
    logic [CpWidth-1:0]           cp;
    logic [7:0]                   bad;
    logic [15:0]                  epos;
    logic [7:0]                   b;

    assign b         = item.data_byte;
    assign pos_plus1 = byte_index + POSITION_WIDTH'(1);
    // Zero-extend before taking the low 16 bits so any width works.
    assign pos_wide  = {16'd0, byte_index};
    assign next_wide = {16'd0, pos_plus1};
    assign value     = {seq.partial_value[CpWidth-7:0], b[5:0]};
    assign due_left  = seq.bytes_due - 2'd1;

    // Lead octet classification.
    always_comb
    begin
        lead_due  = 2'd0;
        lead_init = '0;
        if (b > ILLEGAL_LO_MAX && b <= LEAD2_MAX)
        begin
            lead_due  = 2'd1;
            lead_init = CpWidth'(b[4:0]);
        end
        else if (b > LEAD2_MAX && b <= LEAD3_MAX)
        begin
            lead_due  = 2'd2;
            lead_init = CpWidth'(b[3:0]);
        end
        else if (b > LEAD3_MAX && b <= LEAD4_MAX)
        begin
            lead_due  = 2'd3;
            lead_init = CpWidth'(b[2:0]);
        end
    end

    always_comb
    begin
        emit     = 1'b0;
        status   = ST_OK;
        cp       = '0;
        bad      = 8'd0;
        epos     = 16'd0;
        seq_next = seq;

        if (seq.error_latched)
        begin
            // Octets after an error are dropped until the end mark.
            emit = 1'b0;
        end
        else if (seq.bytes_due == 2'd0)
        begin
            priority if (b <= ASCII_MAX)
            begin
                emit = 1'b1;
                cp   = CpWidth'(b);
            end
            else if (b <= CONT_MAX)
            begin
                emit   = 1'b1;
                status = ST_STRAY_CONT;
                bad    = b;
                epos   = pos_wide[15:0];
            end
            else if (lead_due == 2'd0)
            begin
                emit   = 1'b1;
                status = ST_ILLEGAL;
                bad    = b;
                epos   = pos_wide[15:0];
            end
            else if (item.string_end)
            begin
                // Lead octet as the last of the string: truncated.
                emit   = 1'b1;
                status = ST_BAD_CONT;
                bad    = b;
                epos   = next_wide[15:0];
            end
            else
            begin
                seq_next.partial_value   = lead_init;
                seq_next.bytes_due       = lead_due;
                seq_next.sequence_length = lead_due;
            end
        end
        else if (b[7:6] != 2'b10)
        begin
            emit   = 1'b1;
            status = ST_BAD_CONT;
            bad    = b;
            epos   = pos_wide[15:0];
        end
        else
        begin
            seq_next.partial_value = value;
            seq_next.bytes_due     = due_left;
            if (due_left == 2'd0)
            begin
                emit = 1'b1;
                if (seq.sequence_length == 2'd2)
                begin
                    bad = LEAD3_BASE | value[19:12];
                    if (value < MIN_3BYTE)
                    begin
                        status = ST_OVERLONG;
                    end
                    else if (value >= SURROGATE_LO && value <= SURROGATE_HI)
                    begin
                        status = ST_SURROGATE;
                    end
                end
                else if (seq.sequence_length == 2'd3)
                begin
                    bad = LEAD4_BASE | {5'd0, value[20:18]};
                    if (value < MIN_4BYTE)
                    begin
                        status = ST_OVERLONG;
                    end
                    else if (value > MAX_SCALAR)
                    begin
                        status = ST_TOO_BIG;
                    end
                end
                if (status == ST_OK)
                begin
                    cp  = value;
                    bad = 8'd0;
                end
                else
                begin
                    epos = pos_wide[15:0];
                end
            end
            else if (item.string_end)
            begin
                emit   = 1'b1;
                status = ST_BAD_CONT;
                bad    = b;
                epos   = next_wide[15:0];
            end
        end

        if (emit && status != ST_OK)
        begin
            seq_next               = '0;
            seq_next.error_latched = 1'b1;
        end

        // The end mark starts a fresh string.
        if (item.string_end)
        begin
            seq_next        = '0;
            byte_index_next = '0;
        end
        else
        begin
            byte_index_next = pos_plus1;
        end
    end

    assign result.code_point     = cp;
    assign result.status         = status;
    assign result.bad_octet      = bad;
    assign result.error_position = epos;
    assign result.last_result    = (status != ST_OK) || item.string_end;

endmodule

[rtl/core/utf8_validating_decoder_unit.sv]
// UTF-8 validating decoder: one octet per cycle, input register, decode, result register.
// A byte passes the input register and the decode step; its result, if any, is then held in the result register.
// Throughput: one byte per cycle while the result register is not stalled; a result stall is the only limit.
// Result register stalls hold the input register, which then stalls the byte channel.
// Reset (rst_n low, asynchronous) empties both registers and clears the sequence state.
// Depends on utf8vd_pkg, utf8vd_decode and utf8_validating_decoder_unit_defines.svh.
`include "utf8_validating_decoder_unit_defines.svh"

module utf8_validating_decoder_unit
    import utf8vd_pkg::*;
#(
    parameter int POSITION_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  utf8vd_in_t  byte_item,
    output logic        result_valid,
    input  logic        result_stall,
    output utf8vd_out_t result_item
);

    logic                      in_valid_reg;
    utf8vd_in_t                in_item_reg;
    utf8vd_seq_t               seq_reg;
    utf8vd_seq_t               seq_next;
    logic [POSITION_WIDTH-1:0] index_reg;
    logic [POSITION_WIDTH-1:0] index_next;
    logic                      res_valid_reg;
    utf8vd_out_t               res_item_reg;
    logic                      emit;
    utf8vd_out_t               result;
    logic                      advance;

    // The decode stage moves whenever the result register is empty or being taken.
    assign advance    = !res_valid_reg || !result_stall;
    assign byte_stall = in_valid_reg && !advance;

    utf8vd_decode #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_decode (
        .item            (in_item_reg),
        .seq             (seq_reg),
        .byte_index      (index_reg),
        .seq_next        (seq_next),
        .byte_index_next (index_next),
        .emit            (emit),
        .result          (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            seq_reg       <= '0;
            index_reg     <= '0;
        end
        else
        begin
            if (!byte_stall)
            begin
                in_valid_reg <= byte_valid;
            end
            if (advance)
            begin
                res_valid_reg <= in_valid_reg && emit;
            end
            if (in_valid_reg && advance)
            begin
                seq_reg   <= seq_next;
                index_reg <= index_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            in_item_reg <= byte_item;
        end
        if (advance && in_valid_reg && emit)
        begin
            res_item_reg <= result;
        end
    end

    assign result_valid = res_valid_reg;
    assign result_item  = res_item_reg;

    `UTF8VD_ASSERT_IMPLY(a_ok_clean, clk, rst_n, res_valid_reg && res_item_reg.status == ST_OK, res_item_reg.bad_octet == 8'd0 && res_item_reg.error_position == 16'd0)
    `UTF8VD_ASSERT_IMPLY(a_err_last, clk, rst_n, res_valid_reg && res_item_reg.status != ST_OK, res_item_reg.last_result)
    `UTF8VD_ASSERT_IMPLY(a_latch_idle, clk, rst_n, seq_reg.error_latched, seq_reg.bytes_due == 2'd0 && seq_reg.sequence_length == 2'd0)
    `UTF8VD_ASSERT_NEXT(a_err_latches, clk, rst_n, in_valid_reg && advance && emit && result.status != ST_OK && !in_item_reg.string_end, seq_reg.error_latched)

endmodule

[test/tb_utf8_validating_decoder_unit.sv]
// Self-checking testbench for utf8_validating_decoder_unit: random UTF-8 strings, sound and broken,
// are sent under random gaps and stalls, and each result is checked against an in-bench decoder.
// Depends on utf8vd_pkg and the decoder RTL.
module tb_utf8_validating_decoder_unit;
    import utf8vd_pkg::*;

    localparam int BURST_MAX     = 16;
    localparam int GAP_MAX       = 6;
    localparam int STALL_RUN_MAX = 8;
    localparam int RANDOM_OCTETS = 800;
    localparam int DRAIN_CYCLES  = 10;
    localparam int REPORT_MAX    = 40;
    localparam longint CYCLE_LIMIT = 5_000_000;

    typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_RUNS} stall_mode_e;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_stall;
    utf8vd_in_t  byte_item = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    utf8vd_out_t result_item;

    utf8_validating_decoder_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

    // Decoder state mirrored in the bench.
    logic [CpWidth-1:0] dec_partial = '0;
    logic [1:0]         dec_due = '0;
    logic [1:0]         dec_len = '0;
    logic [15:0]        dec_index = '0;
    logic               dec_dropping = 1'b0;

    utf8vd_out_t pending_decodes[$];
    utf8vd_in_t  octets_to_send[$];
    logic [7:0]  text_buf[$];

    int unsigned octets_accepted = 0;
    int unsigned mismatches = 0;
    longint      cycle_count = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic clear_string();
        dec_partial  = '0;
        dec_due      = '0;
        dec_len      = '0;
        dec_index    = '0;
        dec_dropping = 1'b0;
    endtask

    // Works out the result, if any, of one transferred octet.
    task automatic decode_octet(input utf8vd_in_t octet);
        logic [7:0]         b;
        logic               fin;
        logic [15:0]        pos;
        logic [15:0]        nxt;
        logic               emit;
        logic [2:0]         st;
        logic [CpWidth-1:0] cp;
        logic [CpWidth-1:0] v;
        logic [CpWidth-1:0] init;
        logic [7:0]         bad;
        logic [15:0]        epos;
        logic [1:0]         due;
        utf8vd_out_t        r;
        b    = octet.data_byte;
        fin  = octet.string_end;
        pos  = dec_index;
        nxt  = pos + 16'd1;
        emit = 1'b0;
        st   = ST_OK;
        cp   = '0;
        bad  = '0;
        epos = '0;
        due  = '0;
        init = '0;
        if (dec_dropping)
        begin
            if (fin)
                clear_string();
            else
                dec_index = nxt;
            return;
        end
        if (dec_due == 2'd0)
        begin
            if (b <= ASCII_MAX)
            begin
                emit = 1'b1;
                cp   = {13'd0, b};
            end
            else if (b <= CONT_MAX)
            begin
                emit = 1'b1; st = ST_STRAY_CONT; bad = b; epos = pos;
            end
            else if (b <= ILLEGAL_LO_MAX)
            begin
                emit = 1'b1; st = ST_ILLEGAL; bad = b; epos = pos;
            end
            else if (b <= LEAD2_MAX)
            begin
                due = 2'd1; init = {16'd0, b[4:0]};
            end
            else if (b <= LEAD3_MAX)
            begin
                due = 2'd2; init = {17'd0, b[3:0]};
            end
            else if (b <= LEAD4_MAX)
            begin
                due = 2'd3; init = {18'd0, b[2:0]};
            end
            else
            begin
                emit = 1'b1; st = ST_ILLEGAL; bad = b; epos = pos;
            end
            if (due != 2'd0)
            begin
                if (fin)
                begin
                    // A lead octet that ends the string is a truncated sequence.
                    emit = 1'b1; st = ST_BAD_CONT; bad = b; epos = nxt;
                end
                else
                begin
                    dec_partial = init;
                    dec_due     = due;
                    dec_len     = due;
                end
            end
        end
        else if (b[7:6] != 2'b10)
        begin
            emit = 1'b1; st = ST_BAD_CONT; bad = b; epos = pos;
        end
        else
        begin
            dec_partial = {dec_partial[CpWidth-7:0], b[5:0]};
            dec_due     = dec_due - 2'd1;
            if (dec_due == 2'd0)
            begin
                v    = dec_partial;
                emit = 1'b1;
                // Range checks blame the lead octet rebuilt from the value.
                if (dec_len == 2'd2)
                begin
                    bad = LEAD3_BASE | v[19:12];
                    if (v < MIN_3BYTE)
                        st = ST_OVERLONG;
                    else if (v >= SURROGATE_LO && v <= SURROGATE_HI)
                        st = ST_SURROGATE;
                end
                else if (dec_len == 2'd3)
                begin
                    bad = LEAD4_BASE | {5'd0, v[20:18]};
                    if (v < MIN_4BYTE)
                        st = ST_OVERLONG;
                    else if (v > MAX_SCALAR)
                        st = ST_TOO_BIG;
                end
                if (st == ST_OK)
                begin
                    cp  = v;
                    bad = '0;
                end
                else
                begin
                    epos = pos;
                end
            end
            else if (fin)
            begin
                emit = 1'b1; st = ST_BAD_CONT; bad = b; epos = nxt;
            end
        end
        if (emit)
        begin
            r.code_point     = cp;
            r.status         = st;
            r.bad_octet      = bad;
            r.error_position = epos;
            r.last_result    = (st != ST_OK) || fin;
            pending_decodes.push_back(r);
            if (st != ST_OK)
            begin
                dec_partial  = '0;
                dec_due      = '0;
                dec_len      = '0;
                dec_dropping = 1'b1;
            end
        end
        if (fin)
            clear_string();
        else
            dec_index = nxt;
    endtask

    // Encodes a value into n octets, whether or not n is the shortest form.
    task automatic append_encoded(input logic [CpWidth-1:0] cp, input int n);
        case (n)
            1: text_buf.push_back({1'b0, cp[6:0]});
            2:
            begin
                text_buf.push_back({3'b110, cp[10:6]});
                text_buf.push_back({2'b10, cp[5:0]});
            end
            3:
            begin
                text_buf.push_back({4'b1110, cp[15:12]});
                text_buf.push_back({2'b10, cp[11:6]});
                text_buf.push_back({2'b10, cp[5:0]});
            end
            default:
            begin
                text_buf.push_back({5'b11110, cp[20:18]});
                text_buf.push_back({2'b10, cp[17:12]});
                text_buf.push_back({2'b10, cp[11:6]});
                text_buf.push_back({2'b10, cp[5:0]});
            end
        endcase
    endtask

    function automatic logic [CpWidth-1:0] random_scalar(input int n);
        int unsigned v;
        case (n)
            1: v = $urandom_range(0, 'h7F);
            2: v = $urandom_range('h80, 'h7FF);
            3:
            begin
                // Skip over the surrogate block.
                v = $urandom_range('h800, 'hF7FF);
                if (v >= 'hD800)
                    v = v + 'h800;
            end
            default: v = $urandom_range('h10000, 'h10FFFF);
        endcase
        return v[CpWidth-1:0];
    endfunction

    // Moves the buffered string to the send queue, marking its last octet.
    task automatic flush_text();
        utf8vd_in_t t;
        for (int i = 0; i < text_buf.size(); i++)
        begin
            t.data_byte  = text_buf[i];
            t.string_end = (i == text_buf.size() - 1);
            octets_to_send.push_back(t);
        end
        text_buf.delete();
    endtask

    task automatic make_random_string();
        int kind;
        int nchars;
        int bad_at;
        int n;
        int idx;
        kind   = $urandom_range(0, 9);
        nchars = $urandom_range(1, 8);
        if (kind == 9)
        begin
            repeat ($urandom_range(1, 4))
                text_buf.push_back(8'($urandom_range(0, 255)));
            flush_text();
            return;
        end
        bad_at = (kind >= 6) ? $urandom_range(0, nchars - 1) : -1;
        for (int i = 0; i < nchars; i++)
        begin
            n = $urandom_range(1, 4);
            if (i != bad_at)
            begin
                append_encoded(random_scalar(n), n);
            end
            else if (kind == 6)
            begin
                case ($urandom_range(0, 4))
                    0: append_encoded(CpWidth'($urandom_range(0, 'h7F)), 2);
                    1: append_encoded(CpWidth'($urandom_range(0, 'h7FF)), 3);
                    2: append_encoded(CpWidth'($urandom_range(0, 'hFFFF)), 4);
                    3: append_encoded(CpWidth'($urandom_range('hD800, 'hDFFF)), 3);
                    default: append_encoded(CpWidth'($urandom_range('h110000, 'h13FFFF)), 4);
                endcase
            end
            else if (kind == 7)
            begin
                // Cut a multi-octet character short.
                n = $urandom_range(2, 4);
                append_encoded(random_scalar(n), n);
                repeat ($urandom_range(1, n - 1))
                    void'(text_buf.pop_back());
            end
            else
            begin
                append_encoded(random_scalar(n), n);
                idx = text_buf.size() - 1 - $urandom_range(0, n - 1);
                text_buf[idx] = 8'($urandom_range(0, 255));
            end
        end
        flush_text();
    endtask

    // Sender: bursts of transfers separated by random gaps.
    int gap_left = 0;
    int burst_left = 1;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && !byte_stall)
            begin
                decode_octet(byte_item);
                octets_accepted++;
            end
            if (!byte_valid || !byte_stall)
            begin
                if (gap_left > 0)
                begin
                    byte_valid <= 1'b0;
                    gap_left--;
                end
                else if (octets_to_send.size() > 0)
                begin
                    byte_item  <= octets_to_send.pop_front();
                    byte_valid <= 1'b1;
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ? 200
                                                                 : $urandom_range(1, BURST_MAX);
                        gap_left   = $urandom_range(0, GAP_MAX);
                    end
                end
                else
                begin
                    byte_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall behavior changes from one stretch to the next.
    stall_mode_e stall_mode = STALL_NONE;
    int          stall_mode_left = 0;
    int          stall_run_left = 0;
    logic        stall_run_on = 1'b0;
    logic [1:0]  stall_phase = '0;

    always @(posedge clk)
    begin
        if (stall_mode_left == 0)
        begin
            stall_mode      = stall_mode_e'($urandom_range(0, 3));
            stall_mode_left = $urandom_range(20, 200);
        end
        stall_mode_left--;
        stall_phase++;
        case (stall_mode)
            STALL_NONE:     result_stall <= 1'b0;
            STALL_RANDOM:   result_stall <= ($urandom_range(0, 2) == 0);
            STALL_PERIODIC: result_stall <= (stall_phase == 2'b11);
            default:
            begin
                if (stall_run_left == 0)
                begin
                    stall_run_left = $urandom_range(1, STALL_RUN_MAX);
                    stall_run_on   = ~stall_run_on;
                end
                stall_run_left--;
                result_stall <= stall_run_on;
            end
        endcase
    end

    // Result checker.
    always @(posedge clk)
    begin
        utf8vd_out_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_decodes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result, status %0d code point %h",
                                          result_item.status, result_item.code_point));
            end
            else
            begin
                want = pending_decodes.pop_front();
                if (result_item.code_point != want.code_point)
                    report_mismatch($sformatf("code_point %h, want %h",
                                              result_item.code_point, want.code_point));
                if (result_item.status != want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              result_item.status, want.status));
                if (result_item.bad_octet != want.bad_octet)
                    report_mismatch($sformatf("bad_octet %h, want %h",
                                              result_item.bad_octet, want.bad_octet));
                if (result_item.error_position != want.error_position)
                    report_mismatch($sformatf("error_position %0d, want %0d",
                                              result_item.error_position, want.error_position));
                if (result_item.last_result != want.last_result)
                    report_mismatch($sformatf("last_result %b, want %b",
                                              result_item.last_result, want.last_result));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        logic [7:0] singles[5];
        int unsigned random_goal;
        singles = '{8'h00, 8'h7F, 8'h80, 8'hC1, 8'hFF};
        foreach (singles[i])
        begin
            text_buf.push_back(singles[i]);
            flush_text();
        end
        text_buf = '{8'hDF, 8'hBF};              // largest two-octet value
        flush_text();
        text_buf = '{8'hE0, 8'h80, 8'h80};       // overlong three-octet form
        flush_text();
        text_buf = '{8'hED, 8'hA0, 8'h80};       // surrogate
        flush_text();
        text_buf = '{8'hF4, 8'h8F, 8'hBF, 8'hBF}; // largest scalar
        flush_text();
        text_buf = '{8'hF4, 8'h90, 8'h80, 8'h80}; // above the scalar range
        flush_text();
        text_buf = '{8'hE2, 8'h82};              // truncated after a continuation
        flush_text();
        text_buf = '{8'hC3, 8'h41, 8'h42};       // lead then ASCII, rest dropped
        flush_text();

        random_goal = octets_to_send.size() + RANDOM_OCTETS;
        while (octets_to_send.size() < random_goal)
            make_random_string();

        random_goal = octets_to_send.size();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        while (octets_accepted < random_goal)
            @(posedge clk);
        while (pending_decodes.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
